// File: sv/sparse_set_similarity_top_defines.svh
// assertion macros for the similarity block
`ifndef SPARSE_SET_SIMILARITY_TOP_DEFINES_SVH
`define SPARSE_SET_SIMILARITY_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SSS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define SSS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define SSS_ASSERT_IMP(label, clk, rst_n, pre, post)
`define SSS_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: sv/sss_pkg.sv
`default_nettype none
package sss_pkg;
    localparam int ROWS_DEF = 1024;
    localparam int CAP_DEF = 256;
    localparam int ROW_W = 10;
    localparam int WGT_W = 16;
    localparam int TOT_W = 24;
    localparam int SIM_W = 17;
    localparam logic [TOT_W-1:0] SAT24 = 24'hFFFFFF;
    localparam logic [SIM_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [WGT_W-1:0] ONE_Q8 = 16'd256;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_X      = 2'd1,
        OP_Y      = 2'd2,
        OP_CALC   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        M_JACCARD = 2'd0,
        M_DICE    = 2'd1,
        M_COSINE  = 2'd2,
        M_SUBSET  = 2'd3
    } t_method;

    localparam logic CFG_METHOD = 1'b0;
    localparam logic CFG_USE_W  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_LOADW, S_MRD, S_MCMP, S_MWGT, S_SETUP,
        S_MUL, S_SQRT, S_DIVSET, S_DIV, S_DONE
    } t_state;

    // request to the shared iterative unit
    typedef struct packed {
        logic       start;
        logic       is_sqrt;
        logic [47:0] arg_a;
        logic [47:0] arg_b;
    } t_unit_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [47:0] res;
    } t_unit_rsp;
endpackage
`default_nettype wire

// File: sv/sss_unit.sv
`default_nettype none
// shared iterative unit: restoring divide (one quotient bit a cycle) or
// integer square root (one result bit a cycle)
module sss_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sss_pkg::t_unit_req i_req,
    output sss_pkg::t_unit_rsp      o_rsp
);
    import sss_pkg::*;
    `include "sparse_set_similarity_top_defines.svh"

    logic        r_busy, r_done, r_sqrt;
    logic [5:0]  r_cnt;
    logic [47:0] r_num, r_den, r_q, r_rem, r_bit;
    logic [48:0] rem_sh;
    logic [47:0] trial;

    assign rem_sh = {r_rem, r_num[47]};
    assign trial  = r_q + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.is_sqrt;
                r_num  <= i_req.arg_a;
                r_den  <= i_req.arg_b;
                r_q    <= '0;
                r_rem  <= '0;
                r_bit  <= 48'h1 << 46;
                r_cnt  <= i_req.is_sqrt ? 6'd23 : 6'd47;
            end else if (r_busy) begin
                if (r_sqrt) begin
                    // r_num holds the shrinking radicand
                    if (r_num >= trial) begin
                        r_num <= r_num - trial;
                        r_q   <= (r_q >> 1) + r_bit;
                    end else begin
                        r_q <= r_q >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_num <= r_num << 1;
                    if (rem_sh >= {1'b0, r_den}) begin
                        r_rem <= 48'(rem_sh - {1'b0, r_den});
                        r_q   <= {r_q[46:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[47:0];
                        r_q   <= {r_q[46:0], 1'b0};
                    end
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_q;

    `SSS_ASSERT_NEXT(a_done_ends_busy, i_clk, i_rst_n, r_busy && r_cnt == 6'd0 && !i_req.start, r_done && !r_busy)
    `SSS_ASSERT_IMP(a_no_start_busy, i_clk, i_rst_n, r_busy, !i_req.start)
    `SSS_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy)
endmodule
`default_nettype wire

// File: sv/sss_store.sv
`default_nettype none
// weight table and the two row lists, registered reads
module sss_store #(
    parameter int ROWS = sss_pkg::ROWS_DEF,
    parameter int CAP  = sss_pkg::CAP_DEF,
    localparam int AW  = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int CW  = (CAP > 1) ? $clog2(CAP) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_w_we,
    input  wire logic [AW-1:0]              i_w_addr,
    input  wire logic [sss_pkg::WGT_W-1:0]  i_w_data,
    input  wire logic [AW-1:0]              i_w_raddr,
    output logic [sss_pkg::WGT_W-1:0]       o_w_rdata,
    input  wire logic                       i_x_we,
    input  wire logic                       i_y_we,
    input  wire logic [CW-1:0]              i_xy_waddr,
    input  wire logic [sss_pkg::ROW_W-1:0]  i_xy_wdata,
    input  wire logic [CW-1:0]              i_x_raddr,
    input  wire logic [CW-1:0]              i_y_raddr,
    output logic [sss_pkg::ROW_W-1:0]       o_x_rdata,
    output logic [sss_pkg::ROW_W-1:0]       o_y_rdata
);
    import sss_pkg::*;

    logic [WGT_W-1:0] r_wmem [ROWS];
    logic [ROW_W-1:0] r_xmem [CAP];
    logic [ROW_W-1:0] r_ymem [CAP];

    always_ff @(posedge i_clk) begin
        if (i_w_we) r_wmem[i_w_addr] <= i_w_data;
        o_w_rdata <= r_wmem[i_w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_x_we) r_xmem[i_xy_waddr] <= i_xy_wdata;
        o_x_rdata <= r_xmem[i_x_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_y_we) r_ymem[i_xy_waddr] <= i_xy_wdata;
        o_y_rdata <= r_ymem[i_y_raddr];
    end
endmodule
`default_nettype wire

// File: sv/sparse_set_similarity_top.sv
`default_nettype none
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tdata: row[9:0] weight[25:10], tuser: operation
// m_axis    out  m_axis_tvalid/tready   tdata: similarity[16:0] intersection_weight[40:17]
//                                       overflow[41]
// cfg       in   i_cfg_valid/o_cfg_ready index, data
// weight load: written straight from the accepted beat; element load: S_LOAD, then S_LOADW with weights
// compute: S_MRD and S_MCMP per merge step (+S_MWGT per match with weights), setup, then,
//   unless setup settles the result, a divide, after a square root for cosine, through the shared unit
// reset is synchronous active low and clears counts, totals and config
// the result waits in an output register; loads go on meanwhile and the next
//   compute holds in its last state until the waiting result leaves
module sparse_set_similarity_top #(
    parameter int ROWS = sss_pkg::ROWS_DEF,
    parameter int COLUMN_CAPACITY = sss_pkg::CAP_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // row, weight, zero fill
    input  wire logic [1:0]  s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // similarity, intersection_weight, overflow
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [1:0]  i_cfg_data
);
    import sss_pkg::*;
    `include "sparse_set_similarity_top_defines.svh"

    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = (COLUMN_CAPACITY > 1) ? $clog2(COLUMN_CAPACITY) : 1;
    localparam int NW = $clog2(COLUMN_CAPACITY + 1);

    t_state r_state, n_state;
    t_method r_mode;
    logic r_usew;
    logic [NW-1:0] r_xcnt, r_ycnt, r_kx, r_ky;
    logic [TOT_W-1:0] r_xtot, r_ytot, r_z;
    logic r_drop, r_isx;
    logic [ROW_W-1:0] r_row;
    logic [WGT_W-1:0] r_wt;
    logic [$bits(t_op)-1:0] op_bits;
    logic [47:0] r_prod, r_den;
    logic [SIM_W-1:0] r_sim;
    logic [47:0] r_out;
    logic r_oval;
    logic jac_neg;
    logic out_free;

    t_unit_req ureq;
    t_unit_rsp ursp;

    logic [WGT_W-1:0] w_rdata;
    logic [ROW_W-1:0] x_rdata, y_rdata;
    logic [AW-1:0] w_raddr;
    logic w_we, x_we, y_we;
    logic in_acc;
    t_op op;

    assign op_bits = s_axis_tuser;
    assign op = t_op'(op_bits);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free = !r_oval || m_axis_tready;

    // jaccard divisor below zero
    assign jac_neg = ({1'b0, r_xtot} + {1'b0, r_ytot}) < {1'b0, r_z};

    // in-range check of a row against the table size
    function automatic logic row_ok(input logic [ROW_W-1:0] r);
        return 32'(r) < ROWS;
    endfunction

    assign w_we = in_acc && op == OP_WEIGHT && row_ok(s_axis_tdata[9:0]);
    assign x_we = (r_state == S_LOAD) && r_isx && 32'(r_xcnt) < COLUMN_CAPACITY;
    assign y_we = (r_state == S_LOAD) && !r_isx && 32'(r_ycnt) < COLUMN_CAPACITY;
    assign w_raddr = (r_state == S_MCMP) ? AW'(x_rdata) : AW'(r_row);

    sss_store #(.ROWS(ROWS), .CAP(COLUMN_CAPACITY)) u_store (
        .i_clk(i_clk),
        .i_w_we(w_we), .i_w_addr(AW'(s_axis_tdata[9:0])), .i_w_data(s_axis_tdata[25:10]),
        .i_w_raddr(w_raddr), .o_w_rdata(w_rdata),
        .i_x_we(x_we), .i_y_we(y_we),
        .i_xy_waddr(r_isx ? CW'(r_xcnt) : CW'(r_ycnt)), .i_xy_wdata(r_row),
        .i_x_raddr(CW'(r_kx)), .i_y_raddr(CW'(r_ky)),
        .o_x_rdata(x_rdata), .o_y_rdata(y_rdata)
    );

    sss_unit u_unit (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(ureq), .o_rsp(ursp));

    // element weight of a row given the table read
    function automatic logic [WGT_W-1:0] ewt(input logic uw, input logic ok,
                                             input logic [WGT_W-1:0] rd);
        if (!uw) return ONE_Q8;
        return ok ? rd : '0;
    endfunction

    function automatic logic [TOT_W-1:0] sadd(input logic [TOT_W-1:0] a,
                                              input logic [WGT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + (TOT_W+1)'(b);
        return s[TOT_W] ? SAT24 : s[TOT_W-1:0];
    endfunction

    logic [TOT_W-1:0] add_tot;
    logic [WGT_W-1:0] load_w;
    assign load_w = ewt(r_usew, row_ok(r_row), w_rdata);
    assign add_tot = sadd(r_isx ? r_xtot : r_ytot, load_w);

    always_comb begin
        n_state = r_state;
        ureq = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (op)
                        OP_WEIGHT: n_state = S_IDLE;
                        OP_X, OP_Y: n_state = S_LOAD;
                        OP_CALC: n_state = S_MRD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                if ((r_isx ? x_we : y_we) && r_usew) n_state = S_LOADW;
                else n_state = S_IDLE;
            end
            S_LOADW: n_state = S_IDLE;
            S_MRD: begin
                if (r_kx < r_xcnt && r_ky < r_ycnt) n_state = S_MCMP;
                else n_state = S_SETUP;
            end
            S_MCMP: begin
                if (x_rdata == y_rdata && r_usew) n_state = S_MWGT;
                else n_state = S_MRD;
            end
            S_MWGT: n_state = S_MRD;
            S_SETUP: begin
                if ((r_xtot == '0 && r_ytot == '0) || r_z == '0) n_state = S_DONE;
                else if (r_mode == M_SUBSET && r_xtot > r_z) n_state = S_DONE;
                else if (r_mode == M_JACCARD && jac_neg) n_state = S_DONE;
                else if (r_mode == M_COSINE) n_state = S_MUL;
                else n_state = S_DIVSET;
            end
            S_MUL: begin
                ureq.start = 1'b1;
                ureq.is_sqrt = 1'b1;
                ureq.arg_a = r_prod;
                n_state = S_SQRT;
            end
            S_SQRT: if (ursp.done) n_state = S_DIVSET;
            S_DIVSET: begin
                ureq.start = 1'b1;
                ureq.arg_a = {r_prod[31:0], 16'h0};
                ureq.arg_b = (r_mode == M_COSINE) ? ursp.res : r_den;
                n_state = S_DIV;
            end
            S_DIV: if (ursp.done) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode <= M_JACCARD;
            r_usew <= 1'b0;
            r_xcnt <= '0; r_ycnt <= '0;
            r_xtot <= '0; r_ytot <= '0;
            r_drop <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_METHOD) r_mode <= t_method'(i_cfg_data);
                else r_usew <= i_cfg_data[0];
            end
            if (r_oval && m_axis_tready) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_row <= s_axis_tdata[9:0];
                        r_isx <= (op == OP_X);
                        r_kx <= '0; r_ky <= '0; r_z <= '0;
                    end
                end
                S_LOAD: begin
                    if (r_isx ? x_we : y_we) begin
                        if (r_isx) r_xcnt <= r_xcnt + NW'(1);
                        else r_ycnt <= r_ycnt + NW'(1);
                        if (!r_usew) begin
                            if (r_isx) r_xtot <= add_tot; else r_ytot <= add_tot;
                        end
                    end else begin
                        r_drop <= 1'b1;
                    end
                end
                S_LOADW: begin
                    if (r_isx) r_xtot <= add_tot; else r_ytot <= add_tot;
                end
                S_MCMP: begin
                    r_row <= x_rdata;
                    if (x_rdata < y_rdata) r_kx <= r_kx + NW'(1);
                    else begin
                        if (x_rdata == y_rdata) begin
                            r_kx <= r_kx + NW'(1);
                            if (!r_usew) r_z <= sadd(r_z, ONE_Q8);
                        end
                        r_ky <= r_ky + NW'(1);
                    end
                end
                S_MWGT: r_z <= sadd(r_z, ewt(1'b1, row_ok(r_row), w_rdata));
                S_SETUP: begin
                    if (r_xtot == '0 && r_ytot == '0) r_sim <= ONE_Q16;
                    // jaccard divisor below zero reads as one
                    else if (r_z != '0 && r_mode == M_JACCARD && jac_neg) r_sim <= ONE_Q16;
                    else r_sim <= '0;
                    unique case (r_mode)
                        M_JACCARD: begin
                            r_prod <= 48'(r_z);
                            r_den <= 48'(r_xtot) + 48'(r_ytot) - 48'(r_z);
                        end
                        M_DICE: begin
                            r_prod <= 48'({r_z, 1'b0});
                            r_den <= 48'(r_xtot) + 48'(r_ytot);
                        end
                        M_COSINE: r_prod <= 48'(r_xtot) * 48'(r_ytot);
                        M_SUBSET: begin
                            r_prod <= 48'(r_z);
                            r_den <= 48'(r_ytot);
                        end
                        default: r_prod <= '0;
                    endcase
                end
                S_MUL: r_prod <= 48'(r_z);
                S_DIV: begin
                    if (ursp.done) begin
                        if (ursp.res > 48'(ONE_Q16)) r_sim <= ONE_Q16;
                        else r_sim <= ursp.res[SIM_W-1:0];
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out <= {6'b0, r_drop, r_z, r_sim};
                        r_oval <= 1'b1;
                        r_xcnt <= '0; r_ycnt <= '0;
                        r_xtot <= '0; r_ytot <= '0;
                        r_drop <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata = r_out;

    `SSS_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `SSS_ASSERT_IMP(a_cnt_cap, i_clk, i_rst_n, 1'b1, 32'(r_xcnt) <= COLUMN_CAPACITY && 32'(r_ycnt) <= COLUMN_CAPACITY)
    `SSS_ASSERT_NEXT(a_done_out, i_clk, i_rst_n, r_state == S_DONE && out_free, m_axis_tvalid && r_xcnt == '0)
endmodule
`default_nettype wire
